### hdl/deq_pkg.sv
// types and constants shared by the double-ended queue modules
package deq_pkg;

    localparam int VALUE_W     = 32;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_LIST,
        OP_NOP
    } op_kind_t;

    typedef struct packed {
        op_kind_t                   kind;
        logic signed [VALUE_W-1:0]  value;
    } op_t;

    typedef enum logic [1:0] {
        MODE_CMD  = 2'b01,
        MODE_LIST = 2'b10
    } mode_t;

endpackage

### hdl/deq_ifs.sv
// request and response channel interfaces of the double-ended queue
interface deq_req_if;
    import deq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink (input valid, input cmd, input push_value, output ready);
endinterface

interface deq_rsp_if;
    import deq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] out_value;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        entry_count;
    logic                      last;

    modport source (output valid, output out_value, output status, output entry_count,
                    output last, input ready);
    modport sink (input valid, input out_value, input status, input entry_count,
                  input last, output ready);
endinterface

### hdl/double_ended_queue.sv
// top level of the bounded double-ended queue of signed 32-bit values
// path: an accepted item passes the front op register, the operation queue and the
// back result register before its first result is valid; push, pop and unused codes
// give one result each, a list one per stored entry (one when empty) via the single read port
// reset: asynchronous, active low; empties the queue and zeroes the front index,
// the store contents are not cleared and no clearing pass is needed
module double_ended_queue #(
    parameter int CAPACITY = 16
) (
    input logic       clk,
    input logic       rst_n,
    deq_req_if.sink   req,
    deq_rsp_if.source rsp
);
    import deq_pkg::*;

    op_t  front_op;
    logic front_valid;
    logic front_ready;
    op_t  back_op;
    logic back_valid;
    logic back_ready;

    deq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .op       (front_op),
        .op_valid (front_valid),
        .op_ready (front_ready)
    );

    deq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_op    (front_op),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_op     (back_op),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    deq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (back_op),
        .op_valid (back_valid),
        .op_ready (back_ready),
        .rsp      (rsp)
    );

endmodule

### hdl/deq_front.sv
// front stage: accepts request items and decodes them into operations
module deq_front (
    input  logic         clk,
    input  logic         rst_n,
    deq_req_if.sink      req,
    output deq_pkg::op_t op,
    output logic         op_valid,
    input  logic         op_ready
);
    import deq_pkg::*;

    logic     op_valid_reg;
    logic     op_valid_next;
    op_t      op_reg;
    op_t      op_next;
    op_kind_t kind;

    always_comb
    begin
        unique case (req.cmd)
            CMD_PUSH_FRONT: kind = OP_PUSH_FRONT;
            CMD_PUSH_BACK:  kind = OP_PUSH_BACK;
            CMD_POP_FRONT:  kind = OP_POP_FRONT;
            CMD_POP_BACK:   kind = OP_POP_BACK;
            CMD_LIST:       kind = OP_LIST;
            default:        kind = OP_NOP;
        endcase
    end

    assign req.ready     = !op_valid_reg || op_ready;
    assign op_next.kind  = kind;
    assign op_next.value = req.push_value;

    always_comb
    begin
        op_valid_next = op_valid_reg;
        if (req.valid && req.ready)
        begin
            op_valid_next = 1'b1;
        end
        else if (op_ready)
        begin
            op_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg <= op_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg <= op_next;
        end
    end

    assign op       = op_reg;
    assign op_valid = op_valid_reg;

endmodule

### hdl/deq_queue.sv
// short operation queue between the front and back stages
module deq_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  deq_pkg::op_t push_op,
    input  logic         push_valid,
    output logic         push_ready,
    output deq_pkg::op_t pop_op,
    output logic         pop_valid,
    input  logic         pop_ready
);
    import deq_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    op_t           ent_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [NW-1:0] fill_reg;
    logic [NW-1:0] fill_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (fill_reg != NW'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_op     = ent_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

### hdl/deq_back.sv
// back stage: ring store, front index and count, result register
module deq_back #(
    parameter int CAPACITY = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  deq_pkg::op_t op,
    input  logic         op_valid,
    output logic         op_ready,
    deq_rsp_if.source    rsp
);
    import deq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    logic signed [VALUE_W-1:0] mem [CAPACITY];
    logic signed [VALUE_W-1:0] rdata_reg;

    logic [IW-1:0]       front_reg;
    logic [IW-1:0]       front_next;
    logic [CW-1:0]       occ_reg;
    logic [CW-1:0]       occ_next;
    mode_t               mode_reg;
    mode_t               mode_next;
    logic [IW-1:0]       ptr_reg;
    logic [IW-1:0]       ptr_next;
    logic [CW-1:0]       left_reg;
    logic [CW-1:0]       left_next;

    logic                pend_valid_reg;
    logic                pend_read_reg;
    logic [STATUS_W-1:0] pend_status_reg;
    logic [CW-1:0]       pend_count_reg;
    logic                pend_last_reg;

    logic                can_issue;
    logic                issue;
    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic                mem_re;
    logic [IW-1:0]       mem_raddr;
    logic                res_read;
    logic [STATUS_W-1:0] res_status;
    logic [CW-1:0]       res_count;
    logic                res_last;
    logic                is_full;
    logic                is_empty;

    function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] idx);
        return (idx == IW'(CAPACITY - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] idx);
        return (idx == '0) ? IW'(CAPACITY - 1) : idx - 1'b1;
    endfunction

    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] idx,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(idx) + SW'(off);
        if (sum >= SW'(CAPACITY))
        begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[IW-1:0];
    endfunction

    assign can_issue = !pend_valid_reg || rsp.ready;
    assign is_full   = (occ_reg == CW'(CAPACITY));
    assign is_empty  = (occ_reg == '0);

    always_comb
    begin
        front_next = front_reg;
        occ_next   = occ_reg;
        mode_next  = mode_reg;
        ptr_next   = ptr_reg;
        left_next  = left_reg;
        mem_we     = 1'b0;
        mem_waddr  = front_reg;
        mem_re     = 1'b0;
        mem_raddr  = front_reg;
        op_ready   = 1'b0;
        issue      = 1'b0;
        res_read   = 1'b0;
        res_status = ST_OK;
        res_count  = occ_reg;
        res_last   = 1'b1;
        unique case (mode_reg)
            MODE_LIST:
            begin
                if (can_issue)
                begin
                    issue     = 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg;
                    res_read  = 1'b1;
                    res_last  = (left_reg == CW'(1));
                    ptr_next  = ring_inc(ptr_reg);
                    left_next = left_reg - 1'b1;
                    if (left_reg == CW'(1))
                    begin
                        mode_next = MODE_CMD;
                    end
                end
            end
            MODE_CMD:
            begin
                if (can_issue && op_valid)
                begin
                    op_ready = 1'b1;
                    issue    = 1'b1;
                    unique case (op.kind)
                        OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                front_next = ring_dec(front_reg);
                                mem_we     = 1'b1;
                                mem_waddr  = ring_dec(front_reg);
                                occ_next   = occ_reg + 1'b1;
                                res_count  = occ_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = ring_add(front_reg, occ_reg);
                                occ_next  = occ_reg + 1'b1;
                                res_count = occ_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = front_reg;
                                res_read   = 1'b1;
                                front_next = ring_inc(front_reg);
                                occ_next   = occ_reg - 1'b1;
                                res_count  = occ_reg - 1'b1;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = ring_add(front_reg, occ_reg - 1'b1);
                                res_read  = 1'b1;
                                occ_next  = occ_reg - 1'b1;
                                res_count = occ_reg - 1'b1;
                            end
                        end
                        OP_LIST:
                        begin
                            if (is_empty)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = front_reg;
                                res_read  = 1'b1;
                                res_last  = (occ_reg == CW'(1));
                                if (occ_reg != CW'(1))
                                begin
                                    mode_next = MODE_LIST;
                                    ptr_next  = ring_inc(front_reg);
                                    left_next = occ_reg - 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            res_status = ST_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                mode_next = MODE_CMD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg      <= '0;
            occ_reg        <= '0;
            mode_reg       <= MODE_CMD;
            ptr_reg        <= '0;
            left_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            occ_reg   <= occ_next;
            mode_reg  <= mode_next;
            ptr_reg   <= ptr_next;
            left_reg  <= left_next;
            if (issue)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_read_reg   <= res_read;
            pend_status_reg <= res_status;
            pend_count_reg  <= res_count;
            pend_last_reg   <= res_last;
        end
    end

    // ring store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= op.value;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign rsp.valid       = pend_valid_reg;
    assign rsp.out_value   = pend_read_reg ? rdata_reg : '0;
    assign rsp.status      = pend_status_reg;
    assign rsp.entry_count = COUNT_W'(pend_count_reg);
    assign rsp.last        = pend_last_reg;

endmodule
